[rtl/core/nd_window_offset_generator_top_macros.svh]
// ----------------------------------------------------------------------------
// Window offset generator assertion macros
// Shared concurrent assertion forms, clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef ND_WINDOW_OFFSET_GENERATOR_TOP_MACROS_SVH
`define ND_WINDOW_OFFSET_GENERATOR_TOP_MACROS_SVH

// Assertion that is switched off while reset is high.
`define NWOG_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Assertion that is also checked across reset.
`define NWOG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/nwog_pkg.sv]
// ----------------------------------------------------------------------------
// Window offset generator package
// Field widths, register codes, sequencer states and the setup-to-walk struct.
// ----------------------------------------------------------------------------
package nwog_pkg;

   localparam int CENTER_W  = 36;
   localparam int REL_W     = 31;
   localparam int OFF_W     = 38;
   localparam int DIGIT_W   = 4;
   localparam int HALF_W    = 3;
   localparam int COUNT_W   = 3;
   localparam int WIDTH_W   = 4;
   localparam int SIZE_W    = 10;
   localparam int CSR_IDX_W = 3;

   // Only the first three extents ever enter a stride.
   localparam int NUM_STRIDE_SIZES = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_COUNT    = 3'd0,
      CSR_WINDOW_WIDTH = 3'd1,
      CSR_DIM_SIZE_0   = 3'd2,
      CSR_DIM_SIZE_1   = 3'd3,
      CSR_DIM_SIZE_2   = 3'd4,
      CSR_DIM_SIZE_3   = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      SEQ_STRIDE,
      SEQ_SCALE,
      SEQ_FINISH,
      SEQ_LOAD,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      logic              run;
      logic [HALF_W-1:0] half;
      logic [OFF_W-1:0]  corner;
   } walk_ctl_type;

endpackage

[rtl/core/nwog_if.sv]
// ----------------------------------------------------------------------------
// Window offset generator channel interfaces
// Request, response and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface nwog_req_if
   import nwog_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CENTER_W-1:0] center_index;
   logic                restart;

   modport source (output valid, output center_index, output restart, input ready);
   modport sink   (input valid, input center_index, input restart, output ready);
endinterface

interface nwog_rsp_if
   import nwog_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [REL_W-1:0] relative_offset;
   logic signed [OFF_W-1:0] neighbour_index;
   logic                    last_of_window;

   modport source (output valid, output relative_offset, output neighbour_index,
                   output last_of_window, input ready);
   modport sink   (input valid, input relative_offset, input neighbour_index,
                   input last_of_window, output ready);
endinterface

interface nwog_csr_if
   import nwog_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SIZE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/nwog_setup.sv]
// ----------------------------------------------------------------------------
// Window offset generator setup sequencer
// Holds the registers and derives strides, step deltas and the corner offset.
// ----------------------------------------------------------------------------
module nwog_setup
   import nwog_pkg::*;
#(
   parameter int MAX_DIMS  = 4,
   parameter int MAX_WIDTH = 15,
   parameter int DIM_BITS  = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   nwog_csr_if.sink             csr_ch,
   output walk_ctl_type         ctl,
   output logic [MAX_DIMS-1:0]  active,
   output logic [OFF_W-1:0]     delta [MAX_DIMS]
);

   localparam int CS_W     = DIM_BITS + 1;
   localparam int STRIDE_W = (MAX_DIMS - 1) * DIM_BITS + 1;
   localparam int HS_W     = STRIDE_W + HALF_W;
   localparam int PROD_W   = STRIDE_W + CS_W;
   localparam int STEP_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int SIZE_TOP = 1 << DIM_BITS;

   function automatic logic [CS_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
      logic [CS_W-1:0] r;
      if (s == '0) begin
         r = CS_W'(1);
      end else if (32'(s) > SIZE_TOP) begin
         r = CS_W'(SIZE_TOP);
      end else begin
         r = CS_W'(s);
      end
      return r;
   endfunction

   logic [COUNT_W-1:0] dim_count_ff;
   logic [WIDTH_W-1:0] window_width_ff;
   logic [SIZE_W-1:0]  size_ff [NUM_STRIDE_SIZES];

   seq_state_type      state_ff, state_in;
   logic [STEP_W-1:0]  seq_step_ff, seq_step_in;

   logic [STRIDE_W-1:0] stride_ff [MAX_DIMS];
   logic [OFF_W-1:0]    hs_ff [MAX_DIMS];
   logic [OFF_W-1:0]    hs_in [MAX_DIMS];
   logic [OFF_W-1:0]    delta_ff [MAX_DIMS];
   logic [OFF_W-1:0]    delta_in [MAX_DIMS];
   logic [OFF_W-1:0]    corner_ff, corner_in;

   logic                cfg_write, cfg_restart;
   logic [COUNT_W-1:0]  dims_used;
   logic [WIDTH_W-1:0]  width_cut, width_odd;
   logic [HALF_W-1:0]   half;
   logic [STRIDE_W-1:0] mul_a;
   logic [CS_W-1:0]     mul_b;
   logic [PROD_W-1:0]   mul_full;

   assign csr_ch.ready = 1'b1;
   assign cfg_write    = csr_ch.valid && csr_ch.ready;

   // Register file; any write to a listed register restarts the setup pass.
   always_comb begin
      unique case (csr_index_type'(csr_ch.index))
         CSR_DIM_COUNT, CSR_WINDOW_WIDTH, CSR_DIM_SIZE_0,
         CSR_DIM_SIZE_1, CSR_DIM_SIZE_2, CSR_DIM_SIZE_3: cfg_restart = cfg_write;
         default: cfg_restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff    <= COUNT_W'(3);
         window_width_ff <= WIDTH_W'(3);
         size_ff[0]      <= SIZE_W'(512);
         size_ff[1]      <= SIZE_W'(512);
         size_ff[2]      <= SIZE_W'(512);
      end else if (cfg_write) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_DIM_COUNT:    dim_count_ff    <= csr_ch.data[COUNT_W-1:0];
            CSR_WINDOW_WIDTH: window_width_ff <= csr_ch.data[WIDTH_W-1:0];
            CSR_DIM_SIZE_0:   size_ff[0]      <= csr_ch.data;
            CSR_DIM_SIZE_1:   size_ff[1]      <= csr_ch.data;
            CSR_DIM_SIZE_2:   size_ff[2]      <= csr_ch.data;
            // The fourth extent never enters a stride; the write only restarts.
            CSR_DIM_SIZE_3:   ;
            default:          ;
         endcase
      end
   end

   // Effective dimension count and half window.
   always_comb begin
      if (dim_count_ff == '0) begin
         dims_used = COUNT_W'(1);
      end else if (32'(dim_count_ff) > MAX_DIMS) begin
         dims_used = COUNT_W'(MAX_DIMS);
      end else begin
         dims_used = dim_count_ff;
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
         active[i] = COUNT_W'(i) < dims_used;
      end
      width_cut = (32'(window_width_ff) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : window_width_ff;
      width_odd = width_cut | WIDTH_W'(1);
      half      = width_odd[WIDTH_W-1:1];
   end

   // Next state.
   always_comb begin
      state_in    = state_ff;
      seq_step_in = seq_step_ff;
      if (cfg_restart) begin
         state_in    = SEQ_STRIDE;
         seq_step_in = STEP_W'(1);
      end else begin
         unique case (state_ff)
            SEQ_STRIDE: begin
               if (32'(seq_step_ff) >= MAX_DIMS - 1) begin
                  state_in = SEQ_SCALE;
               end else begin
                  seq_step_in = seq_step_ff + STEP_W'(1);
               end
            end
            SEQ_SCALE:  state_in = SEQ_FINISH;
            SEQ_FINISH: state_in = SEQ_LOAD;
            SEQ_LOAD:   state_in = SEQ_RUN;
            SEQ_RUN:    state_in = SEQ_RUN;
            default:    state_in = SEQ_STRIDE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SEQ_STRIDE;
         seq_step_ff <= STEP_W'(1);
      end else begin
         state_ff    <= state_in;
         seq_step_ff <= seq_step_in;
      end
   end

   // Outputs of the sequencer: shared multiplier operands and walk control.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      for (int k = 1; k < MAX_DIMS; k++) begin
         if (seq_step_ff == STEP_W'(k)) begin
            mul_a = (k == 1) ? STRIDE_W'(1) : stride_ff[k-1];
            mul_b = clamp_size(size_ff[k-1]);
         end
      end
      ctl.run    = (state_ff == SEQ_RUN);
      ctl.half   = half;
      ctl.corner = corner_ff;
   end

   assign mul_full = PROD_W'(mul_a) * PROD_W'(mul_b);

   // h times stride per active dimension, then step deltas and the corner.
   always_comb begin
      logic [OFF_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         hs_in[i] = active[i] ? OFF_W'(HS_W'(half) * HS_W'(stride_ff[i])) : '0;
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
         delta_in[i] = OFF_W'(stride_ff[i]) - (acc << 1);
         acc         = acc + hs_ff[i];
      end
      corner_in = '0 - acc;
   end

   always_ff @(posedge clock) begin
      if (state_ff == SEQ_STRIDE) begin
         stride_ff[0] <= STRIDE_W'(1);
         for (int k = 1; k < MAX_DIMS; k++) begin
            if (seq_step_ff == STEP_W'(k)) begin
               stride_ff[k] <= mul_full[STRIDE_W-1:0];
            end
         end
      end
      if (state_ff == SEQ_SCALE) begin
         hs_ff <= hs_in;
      end
      if (state_ff == SEQ_FINISH) begin
         delta_ff  <= delta_in;
         corner_ff <= corner_in;
      end
   end

   assign delta = delta_ff;

endmodule

[rtl/core/nwog_walk.sv]
// ----------------------------------------------------------------------------
// Window offset generator odometer walk
// Digit registers, running offset and the response register.
// ----------------------------------------------------------------------------
module nwog_walk
   import nwog_pkg::*;
#(
   parameter int MAX_DIMS = 4
) (
   input  logic                clock,
   input  logic                reset,
   nwog_req_if.sink            req_ch,
   nwog_rsp_if.source          rsp_ch,
   input  walk_ctl_type        ctl,
   input  logic [MAX_DIMS-1:0] active,
   input  logic [OFF_W-1:0]    delta [MAX_DIMS]
);

   logic signed [DIGIT_W-1:0] digit_ff [MAX_DIMS];
   logic signed [DIGIT_W-1:0] digit_in [MAX_DIMS];
   logic signed [DIGIT_W-1:0] start_digit [MAX_DIMS];
   logic signed [DIGIT_W-1:0] cur_digit [MAX_DIMS];
   logic signed [DIGIT_W-1:0] step_digit [MAX_DIMS];
   logic [OFF_W-1:0]          offset_ff, offset_in, cur_offset, step_offset;
   logic signed [DIGIT_W-1:0] half_s, neg_half;
   logic                      accept, last;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [REL_W-1:0]          rel_ff;
   logic [OFF_W-1:0]          neigh_ff;
   logic                      last_ff;

   assign half_s   = $signed({1'b0, ctl.half});
   assign neg_half = -half_s;

   assign req_ch.ready = ctl.run && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      logic found;
      found = 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         start_digit[i] = active[i] ? neg_half : '0;
      end
      // A restart item is served from the first corner.
      for (int i = 0; i < MAX_DIMS; i++) begin
         cur_digit[i] = req_ch.restart ? start_digit[i] : digit_ff[i];
      end
      cur_offset = req_ch.restart ? ctl.corner : offset_ff;

      last = 1'b1;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (active[i] && (cur_digit[i] != half_s)) begin
            last = 1'b0;
         end
      end

      // Odometer: the first digit below +h advances, the ones before it wrap.
      // The precomputed delta already folds in the wraps.
      step_digit  = cur_digit;
      step_offset = cur_offset;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (!found && active[i]) begin
            if (cur_digit[i] < half_s) begin
               step_digit[i] = cur_digit[i] + 4'sd1;
               step_offset   = cur_offset + delta[i];
               found         = 1'b1;
            end else begin
               step_digit[i] = neg_half;
            end
         end
      end

      if (!ctl.run || (accept && last)) begin
         digit_in  = start_digit;
         offset_in = ctl.corner;
      end else if (accept) begin
         digit_in  = step_digit;
         offset_in = step_offset;
      end else begin
         digit_in  = digit_ff;
         offset_in = offset_ff;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff  <= digit_in;
      offset_ff <= offset_in;
      if (accept) begin
         rel_ff   <= cur_offset[REL_W-1:0];
         neigh_ff <= OFF_W'(req_ch.center_index) + cur_offset;
         last_ff  <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.relative_offset = $signed(rel_ff);
   assign rsp_ch.neighbour_index = $signed(neigh_ff);
   assign rsp_ch.last_of_window  = last_ff;

endmodule

[rtl/core/nd_window_offset_generator_top.sv]
// ----------------------------------------------------------------------------
// N-dimensional window offset generator
// Walks a cubic window over a column-major image, one neighbour per transfer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                           Accepted when
//  req_ch    in         center_index[35:0], restart                       valid && ready
//  rsp_ch    out        relative_offset[30:0], neighbour_index[37:0], last valid && ready
//  csr_ch    in         index[2:0], data[9:0]                             valid && ready
//
//  One request transfer per cycle is taken while the walk runs and the response register
//  is free or being drained; its response is registered and appears in the next cycle.
//  After reset and after each write to a listed register (indexes 0 to 5) a setup
//  pass runs, in which the shared stride multiplier builds one stride a cycle;
//  req_ch.ready stays low during it.
//  A stalled response holds its register; new requests are taken in the same
//  cycle that the pending response is transferred.
// ----------------------------------------------------------------------------
module nd_window_offset_generator_top
   import nwog_pkg::*;
#(
   parameter int MAX_DIMS  = 4,
   parameter int MAX_WIDTH = 15,
   parameter int DIM_BITS  = 9
) (
   input  logic        clock,
   input  logic        reset,
   nwog_req_if.sink    req_ch,
   nwog_rsp_if.source  rsp_ch,
   nwog_csr_if.sink    csr_ch
);

   // Control handed from the setup sequencer to the walk: run flag, half
   // window and the offset of the first window corner.
   walk_ctl_type        walk_ctl;
   logic [MAX_DIMS-1:0] dim_active;
   // Per-dimension offset change when that digit is the one that advances,
   // with the wraps of all faster digits already included.
   logic [OFF_W-1:0]    step_delta [MAX_DIMS];

   // The setup pass computes strides one per cycle, then h times each stride,
   // then the step deltas and the corner, and finally lets the walk load its
   // first corner before run is raised.
   nwog_setup #(
      .MAX_DIMS  (MAX_DIMS),
      .MAX_WIDTH (MAX_WIDTH),
      .DIM_BITS  (DIM_BITS)
   ) u_setup (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .ctl    (walk_ctl),
      .active (dim_active),
      .delta  (step_delta)
   );

   // The walk keeps the digits and the running offset; a transfer costs two
   // compares per digit, a priority pick and two wide adds (offset, index).
   nwog_walk #(
      .MAX_DIMS (MAX_DIMS)
   ) u_walk (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .ctl    (walk_ctl),
      .active (dim_active),
      .delta  (step_delta)
   );

endmodule

[rtl/core/nwog_checker.sv]
// ----------------------------------------------------------------------------
// Window offset generator port checker
// Watches the top-level channels and checks response timing and payload.
// ----------------------------------------------------------------------------
`include "nd_window_offset_generator_top_macros.svh"

module nwog_checker
   import nwog_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [CENTER_W-1:0]     req_center_index,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [REL_W-1:0] rsp_relative_offset,
   input logic signed [OFF_W-1:0] rsp_neighbour_index,
   input logic                    rsp_last_of_window
);

   logic                                 req_acc;
   logic                                 rsp_stall;
   logic [OFF_W-1:0]                     center_ext, rel_ext, rsp_base;
   logic [REL_W+OFF_W:0]                 rsp_word;

   assign req_acc    = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign center_ext = {{(OFF_W-CENTER_W){1'b0}}, req_center_index};
   assign rel_ext    = {{(OFF_W-REL_W){rsp_relative_offset[REL_W-1]}}, rsp_relative_offset};
   assign rsp_base   = rsp_neighbour_index - rel_ext;
   assign rsp_word   = {rsp_relative_offset, rsp_neighbour_index, rsp_last_of_window};

   `NWOG_ASSERT(a_no_rsp_after_reset, reset |=> !rsp_valid, "response valid right after reset")
   `NWOG_ASSERT_RST(a_rsp_follows_req, req_acc |=> rsp_valid, "no response")
   `NWOG_ASSERT_RST(a_neighbour_sum, req_acc |=> (rsp_base == $past(center_ext)), "bad neighbour")
   `NWOG_ASSERT_RST(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_word), "response not held")

endmodule

bind nd_window_offset_generator_top nwog_checker u_nwog_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_center_index    (req_ch.center_index),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_relative_offset (rsp_ch.relative_offset),
   .rsp_neighbour_index (rsp_ch.neighbour_index),
   .rsp_last_of_window  (rsp_ch.last_of_window)
);

[tb/nd_window_offset_generator_top_tb.sv]
// ----------------------------------------------------------------------------
// Window offset generator testbench
// Drives center indexes through the request channel, writes the window and
// image registers between phases, and checks every response transfer against
// a cycle-free model of the window walk kept inside this module.
// ----------------------------------------------------------------------------
module nd_window_offset_generator_top_tb
   import nwog_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes past the end of the register list. Writes to them must
   // leave both the registers and the walk position alone.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   // Walk geometry limits of the block at its default parameters.
   localparam int  WIDTH_LIMIT = 15;
   localparam int  SIZE_LIMIT  = 512;
   localparam int  DIMS_LIMIT  = 4;

   localparam int  CYCLE_LIMIT     = 250000;
   localparam int  RANDOM_BATCHES  = 15;
   localparam int  BATCH_ITEMS     = 100;
   localparam int  DRAIN_CYCLES    = 10;
   localparam logic [CENTER_W-1:0] CENTER_MAX = '1;

   typedef struct packed {
      logic [CENTER_W-1:0] center;
      logic                restart;
   } window_request_type;

   typedef struct packed {
      logic [REL_W-1:0] rel;
      logic [OFF_W-1:0] neigh;
      logic             last;
   } neighbour_type;

   // ------------------------------------------------------------------------
   // Clock, reset and the signals the testbench drives. Every block input has
   // a known value from time zero through the initializers below.
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic                 req_valid   = 1'b0;
   logic [CENTER_W-1:0]  req_center  = '0;
   logic                 req_restart = 1'b0;
   logic                 rsp_ready   = 1'b0;
   logic                 csr_valid   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [SIZE_W-1:0]    csr_data    = '0;

   nwog_req_if req_if ();
   nwog_rsp_if rsp_if ();
   nwog_csr_if csr_if ();

   assign req_if.valid        = req_valid;
   assign req_if.center_index = req_center;
   assign req_if.restart      = req_restart;
   assign rsp_if.ready        = rsp_ready;
   assign csr_if.valid        = csr_valid;
   assign csr_if.index        = csr_index;
   assign csr_if.data         = csr_data;

   nd_window_offset_generator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Percent chance per cycle that the sender or the receiver sits idle.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   window_request_type pending_requests[$];
   neighbour_type      expected_neighbours[$];
   int                 failures    = 0;
   int                 cycle_count = 0;

   // ------------------------------------------------------------------------
   // Window walk model: the register copies, the per-dimension digits and
   // strides, and the running linear offset of the current neighbour.
   // ------------------------------------------------------------------------
   logic [COUNT_W-1:0] reg_dim_count;
   logic [WIDTH_W-1:0] reg_window_width;
   logic [SIZE_W-1:0]  reg_dim_size [4];
   int                 digit [4];
   longint             stride [4];
   longint             walk_offset;

   // A dimension count of zero means one, anything past four means four.
   function automatic int used_dims();
      int n;
      n = int'(reg_dim_count);
      if (n < 1) n = 1;
      if (n > DIMS_LIMIT) n = DIMS_LIMIT;
      return n;
   endfunction

   // Even widths round up to the next odd value, so zero becomes one.
   function automatic int half_span();
      int w;
      w = int'(reg_window_width);
      if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
      if ((w % 2) == 0) w++;
      return (w - 1) / 2;
   endfunction

   function automatic longint extent(input int i);
      longint s;
      s = longint'(reg_dim_size[i]);
      if (s < 1) s = 1;
      if (s > SIZE_LIMIT) s = SIZE_LIMIT;
      return s;
   endfunction

   // Rebuilds the strides and puts every active digit at the low corner.
   function automatic void rewind_walk();
      int n;
      int h;
      n = used_dims();
      h = half_span();
      stride[0] = 1;
      for (int i = 1; i < 4; i++) stride[i] = stride[i-1] * extent(i-1);
      walk_offset = 0;
      for (int i = 0; i < 4; i++) begin
         digit[i] = (i < n) ? -h : 0;
         walk_offset += longint'(digit[i]) * stride[i];
      end
   endfunction

   function automatic void reset_walk_model();
      reg_dim_count    = 3'd3;
      reg_window_width = 4'd3;
      reg_dim_size[0]  = 10'd512;
      reg_dim_size[1]  = 10'd512;
      reg_dim_size[2]  = 10'd512;
      reg_dim_size[3]  = 10'd1;
      rewind_walk();
   endfunction

   function automatic void apply_register_write(input logic [CSR_IDX_W-1:0] idx,
                                                input logic [SIZE_W-1:0] value);
      case (idx)
         CSR_DIM_COUNT:    reg_dim_count    = value[COUNT_W-1:0];
         CSR_WINDOW_WIDTH: reg_window_width = value[WIDTH_W-1:0];
         CSR_DIM_SIZE_0:   reg_dim_size[0]  = value;
         CSR_DIM_SIZE_1:   reg_dim_size[1]  = value;
         CSR_DIM_SIZE_2:   reg_dim_size[2]  = value;
         CSR_DIM_SIZE_3:   reg_dim_size[3]  = value;
         default:          return;
      endcase
      rewind_walk();
   endfunction

   // Produces the neighbour for one request and advances the odometer, first
   // dimension fastest. The last offset of the window wraps to the first.
   function automatic neighbour_type next_neighbour(input logic [CENTER_W-1:0] center,
                                                    input logic restart);
      neighbour_type nb;
      int            n;
      int            h;
      longint        sum;
      logic          last;
      if (restart) rewind_walk();
      n    = used_dims();
      h    = half_span();
      last = 1'b1;
      for (int i = 0; i < n; i++)
         if (digit[i] != h) last = 1'b0;
      sum      = longint'(center) + walk_offset;
      nb.rel   = walk_offset[REL_W-1:0];
      nb.neigh = sum[OFF_W-1:0];
      nb.last  = last;
      if (last) begin
         rewind_walk();
      end else begin
         for (int i = 0; i < n; i++) begin
            if (digit[i] < h) begin
               digit[i]++;
               walk_offset += stride[i];
               break;
            end
            digit[i] = -h;
            walk_offset -= 2 * h * stride[i];
         end
      end
      return nb;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. A new item is offered only when the channel is empty or
   // the current item transfers at this edge, so valid never drops while an
   // item is still waiting for ready.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      window_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_if.ready) begin
         if (pending_requests.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            item = pending_requests.pop_front();
            req_valid   <= 1'b1;
            req_center  <= item.center;
            req_restart <= item.restart;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure. Ready is redrawn every cycle, so stalls land on
   // every phase of the walk, including the first cycles after setup.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // ------------------------------------------------------------------------
   // Monitor. Register writes and accepted requests update the walk model;
   // each response transfer is checked against the oldest expectation. A
   // response is registered, so it never pairs with a request accepted at the
   // same edge, and the check runs before the new expectation is queued.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      neighbour_type want;
      if (reset) begin
         reset_walk_model();
         expected_neighbours.delete();
      end else begin
         if (csr_if.valid && csr_if.ready)
            apply_register_write(csr_if.index, csr_if.data);

         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_neighbours.size() == 0) begin
               failures++;
               $display("%0t: unexpected response offset %0d neighbour %0d last %0b",
                        $realtime, rsp_if.relative_offset, rsp_if.neighbour_index,
                        rsp_if.last_of_window);
            end else begin
               want = expected_neighbours.pop_front();
               if (rsp_if.relative_offset !== want.rel ||
                   rsp_if.neighbour_index !== want.neigh ||
                   rsp_if.last_of_window !== want.last) begin
                  failures++;
                  // Both sides list offset, neighbour index and last flag.
                  $display("%0t: mismatch expected %0d %0d %0b, actual %0d %0d %0b",
                           $realtime, $signed(want.rel), $signed(want.neigh), want.last,
                           rsp_if.relative_offset, rsp_if.neighbour_index,
                           rsp_if.last_of_window);
               end
            end
         end

         if (req_if.valid && req_if.ready)
            expected_neighbours.push_back(next_neighbour(req_if.center_index,
                                                         req_if.restart));
      end
   end

   // Watchdog: a stuck handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // One register write transfer; the block ties the register channel ready high.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [SIZE_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_valid <= 1'b0;
   endtask

   // Holds the sender back until every queued item has transferred and every
   // expected response has come. Registers are only written after this.
   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_neighbours.size() > 0)
         @(posedge clock);
   endtask

   task automatic queue_request(input logic [CENTER_W-1:0] center, input logic restart);
      window_request_type item;
      item.center  = center;
      item.restart = restart;
      pending_requests.push_back(item);
   endtask

   // Mostly full-range centers, with some near zero (neighbours below the
   // image) and some near the top of the index range.
   function automatic logic [CENTER_W-1:0] random_center();
      logic [63:0] raw;
      int          pick;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(9, 0);
      if (pick == 0) return CENTER_W'($urandom_range(15, 0));
      if (pick == 1) return CENTER_MAX - CENTER_W'($urandom_range(15, 0));
      return raw[CENTER_W-1:0];
   endfunction

   // Extents favor the clamp edges now and then; the rest spans all ten bits.
   function automatic logic [SIZE_W-1:0] random_size();
      case ($urandom_range(7, 0))
         0:       return 10'd0;
         1:       return 10'd1;
         2:       return 10'd512;
         3:       return 10'd513 + SIZE_W'($urandom_range(510, 0));
         default: return SIZE_W'($urandom_range(1023, 0));
      endcase
   endfunction

   // New geometry for a batch. The upper data bits are random so that the
   // register masking is exercised on every count and width write.
   task automatic configure_random();
      logic [SIZE_W-1:0] value;
      value = SIZE_W'($urandom_range(1023, 0));
      if ($urandom_range(9, 0) < 6) value[COUNT_W-1:0] = COUNT_W'($urandom_range(3, 0));
      else value[COUNT_W-1:0] = COUNT_W'($urandom_range(7, 4));
      write_register(CSR_DIM_COUNT, value);
      value = SIZE_W'($urandom_range(1023, 0));
      if ($urandom_range(3, 0) == 0) value[WIDTH_W-1:0] = WIDTH_W'($urandom_range(15, 0));
      else value[WIDTH_W-1:0] = WIDTH_W'($urandom_range(4, 0));
      write_register(CSR_WINDOW_WIDTH, value);
      write_register(CSR_DIM_SIZE_0, random_size());
      write_register(CSR_DIM_SIZE_1, random_size());
      write_register(CSR_DIM_SIZE_2, random_size());
      write_register(CSR_DIM_SIZE_3, random_size());
      if ($urandom_range(3, 0) == 0)
         write_register($urandom_range(1, 0) ? CSR_SPARE_6 : CSR_SPARE_7,
                        SIZE_W'($urandom_range(1023, 0)));
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset geometry: a 3x3x3 window on 512^3. The
      // centers hit both ends of the index range, and a restart in the middle
      // of the walk must send it back to the low corner.
      send_idle_pct = 8;
      recv_idle_pct = 80;
      queue_request('0, 1'b0);
      queue_request(CENTER_MAX, 1'b0);
      queue_request(CENTER_W'(1), 1'b0);
      queue_request(CENTER_W'(262657), 1'b1);
      queue_request(CENTER_MAX, 1'b0);
      queue_request('0, 1'b1);
      wait_drained();

      // Writes past the register list are ignored: the walk keeps its place.
      write_register(CSR_SPARE_6, 10'h3ff);
      write_register(CSR_SPARE_7, 10'h000);
      queue_request(CENTER_W'(1000), 1'b0);
      queue_request(CENTER_W'(2000), 1'b0);
      wait_drained();

      // Zero dimensions and zero width collapse to a single-point window, so
      // every transfer is the last of its window.
      write_register(CSR_DIM_COUNT, 10'h000);
      write_register(CSR_WINDOW_WIDTH, 10'h000);
      queue_request(CENTER_W'(7), 1'b0);
      queue_request(CENTER_MAX, 1'b1);
      queue_request('0, 1'b0);
      wait_drained();

      // Widest window over four dimensions with the extents at their clamp
      // points: zero reads as one, and 1023 reads as 512. The high data bits
      // of the count and width writes must be masked off.
      write_register(CSR_WINDOW_WIDTH, 10'h3ff);
      write_register(CSR_DIM_COUNT, 10'h3ff);
      write_register(CSR_DIM_SIZE_0, 10'd0);
      write_register(CSR_DIM_SIZE_1, 10'd1023);
      write_register(CSR_DIM_SIZE_2, 10'd1023);
      write_register(CSR_DIM_SIZE_3, 10'd0);
      queue_request('0, 1'b0);
      queue_request(CENTER_MAX, 1'b0);
      queue_request('0, 1'b0);
      queue_request(CENTER_W'(3), 1'b0);
      wait_drained();

      // An even width rounds up: width 2 on one dimension is a 3-point walk.
      write_register(CSR_WINDOW_WIDTH, 10'd2);
      write_register(CSR_DIM_COUNT, 10'd1);
      queue_request(CENTER_W'(5), 1'b0);
      queue_request(CENTER_W'(5), 1'b0);
      queue_request(CENTER_W'(5), 1'b0);
      wait_drained();

      // Random part. The idle pattern flips after a third of the batches and
      // goes away for the last third. Most batches get a new geometry; the
      // others continue the walk across a full drain of the pipeline.
      for (int b = 0; b < RANDOM_BATCHES; b++) begin
         if (b == RANDOM_BATCHES / 3) begin
            send_idle_pct = 80;
            recv_idle_pct = 8;
         end else if (b == 2 * RANDOM_BATCHES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (b == 0 || $urandom_range(3, 0) != 0) configure_random();
         for (int i = 0; i < BATCH_ITEMS; i++)
            queue_request(random_center(), $urandom_range(19, 0) == 0);
         wait_drained();
      end

      // Let any stray response show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_neighbours.size() != 0) failures++;
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/nwog_pkg.sv
rtl/core/nwog_if.sv
rtl/core/nwog_setup.sv
rtl/core/nwog_walk.sv
rtl/core/nd_window_offset_generator_top.sv
rtl/core/nwog_checker.sv
tb/nd_window_offset_generator_top_tb.sv
